### src/lqm_pkg.sv
package lqm_pkg;

    // Fixed field widths of the request and result items
    localparam int OP_W         = 2;
    localparam int LIST_FIELD_W = 4;
    localparam int SLOT_FIELD_W = 6;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 16;

    // Request operations
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_CLEAR     = 7'b0000001,
        ST_IDLE      = 7'b0000010,
        ST_LOOK      = 7'b0000100,
        ST_POP       = 7'b0001000,
        ST_LINK_NEXT = 7'b0010000,
        ST_LINK_PREV = 7'b0100000,
        ST_DONE      = 7'b1000000
    } state_t;

    // Field write enables of one link memory row
    typedef struct packed {
        logic member;
        logic next;
        logic prev;
    } link_wen_t;

endpackage

### src/lqm_link_mem.sv
module lqm_link_mem #(
    parameter int ADDR_W = 10,
    parameter int DEPTH  = 1024,
    parameter int LINK_W = 7
) (
    input  logic              clk,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic              rd_member,
    output logic [LINK_W-1:0] rd_next,
    output logic [LINK_W-1:0] rd_prev,
    input  lqm_pkg::link_wen_t wen,
    input  logic [ADDR_W-1:0] waddr,
    input  logic              wd_member,
    input  logic [LINK_W-1:0] wd_next,
    input  logic [LINK_W-1:0] wd_prev
);
    import lqm_pkg::*;

    localparam int WORD_W = 2 * LINK_W + 1;

    // Row layout: {member, next, prev}
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_reg;

    // Write selected fields; read one row into a read register
    always_ff @(posedge clk)
    begin
        if (wen.member)
        begin
            mem[waddr][WORD_W-1] <= wd_member;
        end
        if (wen.next)
        begin
            mem[waddr][2*LINK_W-1:LINK_W] <= wd_next;
        end
        if (wen.prev)
        begin
            mem[waddr][LINK_W-1:0] <= wd_prev;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    assign rd_member = rd_reg[WORD_W-1];
    assign rd_next   = rd_reg[2*LINK_W-1:LINK_W];
    assign rd_prev   = rd_reg[LINK_W-1:0];

endmodule

### src/lqm_head_tail.sv
module lqm_head_tail #(
    parameter int ADDR_W    = 4,
    parameter int NUM_LISTS = 16,
    parameter int LINK_W    = 7,
    parameter int NONE_VAL  = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [LINK_W-1:0] rd_head,
    output logic [LINK_W-1:0] rd_tail,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [LINK_W-1:0] wd_head,
    input  logic [LINK_W-1:0] wd_tail
);
    import lqm_pkg::*;

    localparam logic [LINK_W-1:0] NONE = LINK_W'(NONE_VAL);

    // Row layout: {head, tail}
    logic [2*LINK_W-1:0] mem [NUM_LISTS];
    logic [2*LINK_W-1:0] rd_reg;
    logic [NUM_LISTS-1:0] vld_reg;
    logic                 rd_vld_reg;

    // Mark a list written; reset makes every list empty at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_vld_reg <= vld_reg[raddr];
            end
        end
    end

    // Storage with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wd_head, wd_tail};
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    // An unwritten list reads as empty
    assign rd_head = rd_vld_reg ? rd_reg[2*LINK_W-1:LINK_W] : NONE;
    assign rd_tail = rd_vld_reg ? rd_reg[LINK_W-1:0] : NONE;

endmodule

### src/lqm_ctrl.sv
module lqm_ctrl #(
    parameter int NUM_SLOTS = 64,
    parameter int NUM_LISTS = 16,
    parameter int SLOT_AW   = $clog2(NUM_SLOTS),
    parameter int LIST_AW   = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1,
    parameter int LINK_W    = $clog2(NUM_SLOTS + 1),
    parameter int LINK_AW   = LIST_AW + SLOT_AW
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request side
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lqm_pkg::op_t                      in_op,
    input  logic [lqm_pkg::LIST_FIELD_W-1:0]  in_list,
    input  logic [lqm_pkg::SLOT_FIELD_W-1:0]  in_slot,
    // result side
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_done,
    output logic [lqm_pkg::SLOT_FIELD_W-1:0]  out_popped,
    output logic                              out_already,
    output logic                              out_empty,
    // link memory
    output logic                              lk_re,
    output logic [LINK_AW-1:0]                lk_raddr,
    input  logic                              lk_rd_member,
    input  logic [LINK_W-1:0]                 lk_rd_next,
    input  logic [LINK_W-1:0]                 lk_rd_prev,
    output lqm_pkg::link_wen_t                lk_wen,
    output logic [LINK_AW-1:0]                lk_waddr,
    output logic                              lk_wd_member,
    output logic [LINK_W-1:0]                 lk_wd_next,
    output logic [LINK_W-1:0]                 lk_wd_prev,
    // head/tail table
    output logic                              ht_re,
    output logic [LIST_AW-1:0]                ht_raddr,
    input  logic [LINK_W-1:0]                 ht_rd_head,
    input  logic [LINK_W-1:0]                 ht_rd_tail,
    output logic                              ht_we,
    output logic [LINK_W-1:0]                 ht_wd_head,
    output logic [LINK_W-1:0]                 ht_wd_tail
);
    import lqm_pkg::*;

    localparam int                 LINK_DEPTH = NUM_LISTS * (2 ** SLOT_AW);
    localparam logic [LINK_AW-1:0] CLR_LAST   = LINK_AW'(LINK_DEPTH - 1);
    localparam logic [LINK_W-1:0]  NONE       = LINK_W'(NUM_SLOTS);

    function automatic logic is_slot(input logic [LINK_W-1:0] v);
        return v < NONE;
    endfunction

    function automatic logic [LINK_W-1:0] clamp(input logic [LINK_W-1:0] v);
        return is_slot(v) ? v : NONE;
    endfunction

    state_t               state_reg, state_next;
    logic [LINK_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    op_t                  op_reg, op_next;
    logic [LIST_AW-1:0]   list_reg, list_next;
    logic [SLOT_AW-1:0]   slot_reg, slot_next;
    logic                 list_ok_reg, list_ok_next;
    logic                 slot_ok_reg, slot_ok_next;
    logic [SLOT_AW-1:0]   nxt_addr_reg, nxt_addr_next;
    logic [LINK_W-1:0]    nxt_val_reg, nxt_val_next;
    logic [SLOT_AW-1:0]   prv_addr_reg, prv_addr_next;
    logic [LINK_W-1:0]    prv_val_reg, prv_val_next;
    logic                 prv_pend_reg, prv_pend_next;
    logic                 res_done_reg, res_done_next;
    logic [SLOT_FIELD_W-1:0] res_popped_reg, res_popped_next;
    logic                 res_already_reg, res_already_next;
    logic                 res_empty_reg, res_empty_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_done_reg;
    logic [SLOT_FIELD_W-1:0] out_popped_reg;
    logic                 out_already_reg;
    logic                 out_empty_reg;

    logic                 finish;
    logic                 out_free;
    logic                 out_load;
    logic [LIST_AW-1:0]   in_list_idx;
    logic [SLOT_AW-1:0]   in_slot_idx;
    logic                 in_list_ok;
    logic                 in_slot_ok;
    logic [LINK_W-1:0]    slot_link;
    logic [LINK_W-1:0]    rm_prev;
    logic [LINK_W-1:0]    rm_next;
    logic [LINK_W-1:0]    pop_next;

    // Decode the incoming request
    assign in_list_idx = LIST_AW'(in_list);
    assign in_slot_idx = SLOT_AW'(in_slot);
    assign in_list_ok  = int'(in_list) < NUM_LISTS;
    assign in_slot_ok  = int'(in_slot) < NUM_SLOTS;
    assign slot_link   = LINK_W'(slot_reg);
    assign rm_prev     = clamp(lk_rd_prev);
    assign rm_next     = clamp(lk_rd_next);
    assign pop_next    = clamp(lk_rd_next);

    // Result register frees when empty or taken this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = finish && out_free;

    // Sequence reads, link updates and result handoff
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        op_next          = op_reg;
        list_next        = list_reg;
        slot_next        = slot_reg;
        list_ok_next     = list_ok_reg;
        slot_ok_next     = slot_ok_reg;
        nxt_addr_next    = nxt_addr_reg;
        nxt_val_next     = nxt_val_reg;
        prv_addr_next    = prv_addr_reg;
        prv_val_next     = prv_val_reg;
        prv_pend_next    = prv_pend_reg;
        res_done_next    = res_done_reg;
        res_popped_next  = res_popped_reg;
        res_already_next = res_already_reg;
        res_empty_next   = res_empty_reg;
        in_ready         = 1'b0;
        lk_re            = 1'b0;
        lk_raddr         = {in_list_idx, in_slot_idx};
        lk_wen           = '0;
        lk_waddr         = {list_reg, slot_reg};
        lk_wd_member     = 1'b0;
        lk_wd_next       = NONE;
        lk_wd_prev       = NONE;
        ht_re            = 1'b0;
        ht_raddr         = in_list_idx;
        ht_we            = 1'b0;
        ht_wd_head       = ht_rd_head;
        ht_wd_tail       = ht_rd_tail;
        finish           = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every link row, dropping membership
                lk_wen.member = 1'b1;
                lk_waddr      = clr_cnt_reg;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next      = in_op;
                    list_next    = in_list_idx;
                    slot_next    = in_slot_idx;
                    list_ok_next = in_list_ok;
                    slot_ok_next = in_slot_ok;
                    ht_re        = in_list_ok;
                    lk_re        = in_list_ok && in_slot_ok;
                    state_next   = ST_LOOK;
                end
            end

            ST_LOOK:
            begin
                res_done_next    = 1'b0;
                res_popped_next  = '0;
                res_already_next = 1'b0;
                res_empty_next   = !is_slot(ht_rd_head);
                prv_pend_next    = 1'b0;
                if (!list_ok_reg)
                begin
                    res_empty_next = 1'b1;
                    finish         = 1'b1;
                end
                else
                begin
                    unique case (op_reg)
                        OP_APPEND:
                        begin
                            if (!slot_ok_reg)
                            begin
                                finish = 1'b1;
                            end
                            else if (lk_rd_member)
                            begin
                                res_already_next = 1'b1;
                                finish           = 1'b1;
                            end
                            else
                            begin
                                // New tail row, then hook the old tail to it
                                lk_wen       = '{member: 1'b1, next: 1'b1, prev: 1'b1};
                                lk_wd_member = 1'b1;
                                lk_wd_next   = NONE;
                                lk_wd_prev   = ht_rd_tail;
                                ht_we        = 1'b1;
                                ht_wd_tail   = slot_link;
                                if (!is_slot(ht_rd_tail))
                                begin
                                    ht_wd_head = slot_link;
                                end
                                res_done_next  = 1'b1;
                                res_empty_next = 1'b0;
                                if (is_slot(ht_rd_tail))
                                begin
                                    nxt_addr_next = ht_rd_tail[SLOT_AW-1:0];
                                    nxt_val_next  = slot_link;
                                    state_next    = ST_LINK_NEXT;
                                end
                                else
                                begin
                                    finish = 1'b1;
                                end
                            end
                        end

                        OP_POP:
                        begin
                            if (!is_slot(ht_rd_head))
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                lk_re      = 1'b1;
                                lk_raddr   = {list_reg, ht_rd_head[SLOT_AW-1:0]};
                                state_next = ST_POP;
                            end
                        end

                        OP_REMOVE:
                        begin
                            if (!slot_ok_reg || !lk_rd_member)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                // Unlink: fix head/tail now, neighbors after
                                lk_wen.member = 1'b1;
                                lk_wd_member  = 1'b0;
                                ht_we         = 1'b1;
                                if (!is_slot(rm_prev))
                                begin
                                    ht_wd_head = rm_next;
                                end
                                if (!is_slot(rm_next))
                                begin
                                    ht_wd_tail = rm_prev;
                                end
                                res_done_next  = 1'b1;
                                res_empty_next = !is_slot(ht_wd_head);
                                nxt_addr_next  = rm_prev[SLOT_AW-1:0];
                                nxt_val_next   = rm_next;
                                prv_addr_next  = rm_next[SLOT_AW-1:0];
                                prv_val_next   = rm_prev;
                                prv_pend_next  = is_slot(rm_next);
                                if (is_slot(rm_prev))
                                begin
                                    state_next = ST_LINK_NEXT;
                                end
                                else if (is_slot(rm_next))
                                begin
                                    state_next = ST_LINK_PREV;
                                end
                                else
                                begin
                                    finish = 1'b1;
                                end
                            end
                        end

                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                // Head row is in the read register; advance the head
                lk_wen.member   = 1'b1;
                lk_waddr        = {list_reg, ht_rd_head[SLOT_AW-1:0]};
                lk_wd_member    = 1'b0;
                ht_we           = 1'b1;
                ht_wd_head      = pop_next;
                if (!is_slot(pop_next))
                begin
                    ht_wd_tail = NONE;
                end
                res_done_next   = 1'b1;
                res_popped_next = SLOT_FIELD_W'(ht_rd_head);
                res_empty_next  = !is_slot(pop_next);
                if (is_slot(pop_next))
                begin
                    prv_addr_next = pop_next[SLOT_AW-1:0];
                    prv_val_next  = NONE;
                    prv_pend_next = 1'b1;
                    state_next    = ST_LINK_PREV;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            ST_LINK_NEXT:
            begin
                lk_wen.next = 1'b1;
                lk_waddr    = {list_reg, nxt_addr_reg};
                lk_wd_next  = nxt_val_reg;
                if (prv_pend_reg)
                begin
                    state_next = ST_LINK_PREV;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            ST_LINK_PREV:
            begin
                lk_wen.prev = 1'b1;
                lk_waddr    = {list_reg, prv_addr_reg};
                lk_wd_prev  = prv_val_reg;
                finish      = 1'b1;
            end

            ST_DONE:
            begin
                finish = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand the result over, or hold it until the output frees
        if (finish)
        begin
            state_next = out_free ? ST_IDLE : ST_DONE;
        end
    end

    // Output register: drop on take, load on finish
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        list_reg        <= list_next;
        slot_reg        <= slot_next;
        list_ok_reg     <= list_ok_next;
        slot_ok_reg     <= slot_ok_next;
        nxt_addr_reg    <= nxt_addr_next;
        nxt_val_reg     <= nxt_val_next;
        prv_addr_reg    <= prv_addr_next;
        prv_val_reg     <= prv_val_next;
        prv_pend_reg    <= prv_pend_next;
        res_done_reg    <= res_done_next;
        res_popped_reg  <= res_popped_next;
        res_already_reg <= res_already_next;
        res_empty_reg   <= res_empty_next;
        if (out_load)
        begin
            out_done_reg    <= res_done_next;
            out_popped_reg  <= res_popped_next;
            out_already_reg <= res_already_next;
            out_empty_reg   <= res_empty_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_done    = out_done_reg;
    assign out_popped  = out_popped_reg;
    assign out_already = out_already_reg;
    assign out_empty   = out_empty_reg;

endmodule

### src/multi_list_linked_queue_manager_unit.sv
// Keeps NUM_LISTS FIFO lists over a pool of NUM_SLOTS slots as doubly linked
// lists, one link row per (list, slot) pair in a single-port-write link RAM,
// with head and tail pointers in a small per-list table. A request is taken
// when the block is idle, even while the previous result still waits on the
// output. Query, out-of-range and no-op requests end in the look-up state;
// append adds a state to link the old tail, pop one to unlink the head and
// one to relink the new head, and remove of a member one per rewritten
// neighbor link, as the link RAM takes one row write per cycle. After
// reset, all NUM_LISTS * 2**ceil(log2(NUM_SLOTS)) link RAM rows (1024 at the
// defaults) are swept to clear membership, with no request taken until then.
module multi_list_linked_queue_manager_unit #(
    parameter int NUM_SLOTS = 64,
    parameter int NUM_LISTS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // op[1:0], list_sel[5:2], slot[11:6], zero[15:12]
    input  logic [lqm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // done_res[0], popped_slot[6:1], already_member[7], now_empty[8], zero[15:9]
    output logic [lqm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import lqm_pkg::*;

    localparam int SLOT_AW    = $clog2(NUM_SLOTS);
    localparam int LIST_AW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int LINK_W     = $clog2(NUM_SLOTS + 1);
    localparam int LINK_AW    = LIST_AW + SLOT_AW;
    localparam int LINK_DEPTH = NUM_LISTS * (2 ** SLOT_AW);

    logic                    lk_re;
    logic [LINK_AW-1:0]      lk_raddr;
    logic                    lk_rd_member;
    logic [LINK_W-1:0]       lk_rd_next;
    logic [LINK_W-1:0]       lk_rd_prev;
    link_wen_t               lk_wen;
    logic [LINK_AW-1:0]      lk_waddr;
    logic                    lk_wd_member;
    logic [LINK_W-1:0]       lk_wd_next;
    logic [LINK_W-1:0]       lk_wd_prev;
    logic                    ht_re;
    logic [LIST_AW-1:0]      ht_raddr;
    logic [LINK_W-1:0]       ht_rd_head;
    logic [LINK_W-1:0]       ht_rd_tail;
    logic                    ht_we;
    logic [LINK_W-1:0]       ht_wd_head;
    logic [LINK_W-1:0]       ht_wd_tail;
    logic                    res_done;
    logic [SLOT_FIELD_W-1:0] res_popped;
    logic                    res_already;
    logic                    res_empty;

    function automatic logic [LIST_AW-1:0] list_waddr(input logic [LINK_AW-1:0] a);
        return a[LINK_AW-1:SLOT_AW];
    endfunction

    // Sequencer and result register
    lqm_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .NUM_LISTS (NUM_LISTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_op        (op_t'(s_axis_tdata[1:0])),
        .in_list      (s_axis_tdata[5:2]),
        .in_slot      (s_axis_tdata[11:6]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_done     (res_done),
        .out_popped   (res_popped),
        .out_already  (res_already),
        .out_empty    (res_empty),
        .lk_re        (lk_re),
        .lk_raddr     (lk_raddr),
        .lk_rd_member (lk_rd_member),
        .lk_rd_next   (lk_rd_next),
        .lk_rd_prev   (lk_rd_prev),
        .lk_wen       (lk_wen),
        .lk_waddr     (lk_waddr),
        .lk_wd_member (lk_wd_member),
        .lk_wd_next   (lk_wd_next),
        .lk_wd_prev   (lk_wd_prev),
        .ht_re        (ht_re),
        .ht_raddr     (ht_raddr),
        .ht_rd_head   (ht_rd_head),
        .ht_rd_tail   (ht_rd_tail),
        .ht_we        (ht_we),
        .ht_wd_head   (ht_wd_head),
        .ht_wd_tail   (ht_wd_tail)
    );

    // Per-pair link rows
    lqm_link_mem #(
        .ADDR_W (LINK_AW),
        .DEPTH  (LINK_DEPTH),
        .LINK_W (LINK_W)
    ) u_link_mem (
        .clk       (clk),
        .re        (lk_re),
        .raddr     (lk_raddr),
        .rd_member (lk_rd_member),
        .rd_next   (lk_rd_next),
        .rd_prev   (lk_rd_prev),
        .wen       (lk_wen),
        .waddr     (lk_waddr),
        .wd_member (lk_wd_member),
        .wd_next   (lk_wd_next),
        .wd_prev   (lk_wd_prev)
    );

    // Per-list head and tail
    lqm_head_tail #(
        .ADDR_W    (LIST_AW),
        .NUM_LISTS (NUM_LISTS),
        .LINK_W    (LINK_W),
        .NONE_VAL  (NUM_SLOTS)
    ) u_head_tail (
        .clk     (clk),
        .rst_n   (rst_n),
        .re      (ht_re),
        .raddr   (ht_raddr),
        .rd_head (ht_rd_head),
        .rd_tail (ht_rd_tail),
        .we      (ht_we),
        .waddr   (list_waddr(lk_waddr)),
        .wd_head (ht_wd_head),
        .wd_tail (ht_wd_tail)
    );

    // Pack the result transaction
    assign m_axis_tdata = {
        (OUT_TDATA_W - SLOT_FIELD_W - 3)'(0),
        res_empty,
        res_already,
        res_popped,
        res_done
    };

endmodule
